### rtl/btsp_pkg.sv
// ----------------------------------------------------------------------------
// BER-TLV stream parser package
// Shared result word layout, result codes and queue sizing.
// ----------------------------------------------------------------------------
package btsp_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd2;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;

  localparam logic [4:0] TAG_MULTI_BYTE = 5'h1F;
  localparam logic [6:0] LEN_ONE_BYTE   = 7'd1;
  localparam logic [6:0] LEN_TWO_BYTES  = 7'd2;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [15:0] value_length;
    logic [2:0]  depth;
    logic [7:0]  value_byte;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### rtl/btsp_core.sv
// ----------------------------------------------------------------------------
// BER-TLV parse core
// Holds the parse state and nesting stack and turns one accepted byte into
// up to two result words in the same cycle.
// ----------------------------------------------------------------------------
module btsp_core #(
  parameter int MAX_DEPTH    = 5,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  output btsp_pkg::push_t   push
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int EW = ((OFFSET_WIDTH > 16) ? OFFSET_WIDTH : 16) + 1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_TAG1  = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [15:0]             tag_hold_r, tag_hold_nxt;
  logic [15:0]             len_acc_r, len_acc_nxt;
  logic [1:0]              len_left_r, len_left_nxt;
  logic [15:0]             value_left_r, value_left_nxt;
  logic [OFFSET_WIDTH-1:0] byte_off_r, byte_off_nxt;
  logic [LW-1:0]           open_r, open_nxt;
  logic [OFFSET_WIDTH-1:0] level_end_r [MAX_DEPTH];

  logic [OFFSET_WIDTH-1:0] off;
  logic [LW-1:0]           pop_open;
  logic [IW-1:0]           top_idx;
  logic [OFFSET_WIDTH-1:0] top_end;
  logic [15:0]             hdr_len;
  logic [7:0]              hdr_first;
  logic [EW-1:0]           hdr_end;
  logic                    hdr_overrun;
  logic                    hdr_go;
  logic                    push_en;
  logic [1:0]              left_dec;
  logic [15:0]             value_dec;
  logic                    trunc;
  btsp_pkg::result_t       res0, res1;
  logic                    res0_valid;

  assign off     = (byte_off_r != OFFSET_MAX) ? byte_off_r + 1'b1 : OFFSET_MAX;
  assign top_idx = IW'(open_r - 1'b1);
  assign top_end = level_end_r[top_idx];

  // Levels are nested, so the run of levels ending here sits on top of the stack.
  always_comb begin
    pop_open = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((LW'(i) < open_r) && (level_end_r[i] != off)) begin
        pop_open = LW'(i + 1);
      end
    end
  end

  assign hdr_len   = (phase_r == PH_LEN1) ? {8'h00, data_byte} : {len_acc_r[7:0], data_byte};
  assign hdr_first = (tag_hold_r[12:8] == btsp_pkg::TAG_MULTI_BYTE) ? tag_hold_r[15:8]
                                                                    : tag_hold_r[7:0];
  assign hdr_end   = EW'(off) + EW'(hdr_len);
  assign hdr_overrun = (hdr_end >= EW'(OFFSET_MAX)) ||
                       ((open_r != '0) && (hdr_end > EW'(top_end)));
  assign left_dec  = (len_left_r != 2'd0) ? len_left_r - 2'd1 : 2'd0;
  assign value_dec = (value_left_r != 16'd0) ? value_left_r - 16'd1 : 16'd0;

  always_comb begin
    phase_nxt      = phase_r;
    tag_hold_nxt   = tag_hold_r;
    len_acc_nxt    = len_acc_r;
    len_left_nxt   = len_left_r;
    value_left_nxt = value_left_r;
    byte_off_nxt   = off;
    open_nxt       = open_r;
    hdr_go         = 1'b0;
    push_en        = 1'b0;
    res0_valid     = 1'b0;
    res0           = '0;
    res0.depth     = 3'(open_r);
    res1           = '0;

    unique case (phase_r)
      PH_TAG1: begin
        tag_hold_nxt = {8'h00, data_byte};
        phase_nxt    = (data_byte[4:0] == btsp_pkg::TAG_MULTI_BYTE) ? PH_TAG2 : PH_LEN1;
      end
      PH_TAG2: begin
        tag_hold_nxt = {tag_hold_r[7:0], data_byte};
        phase_nxt    = PH_LEN1;
      end
      PH_LEN1: begin
        if (!data_byte[7]) begin
          hdr_go = 1'b1;
        end else if (data_byte[6:0] == btsp_pkg::LEN_ONE_BYTE ||
                     data_byte[6:0] == btsp_pkg::LEN_TWO_BYTES) begin
          len_acc_nxt  = 16'd0;
          len_left_nxt = data_byte[1:0];
          phase_nxt    = PH_LENX;
        end else begin
          res0_valid      = 1'b1;
          res0.kind       = btsp_pkg::KIND_ERROR;
          res0.error_code = btsp_pkg::ERR_LEN_LONG;
          phase_nxt       = PH_SKIP;
        end
      end
      PH_LENX: begin
        len_acc_nxt  = hdr_len;
        len_left_nxt = left_dec;
        hdr_go       = (left_dec == 2'd0);
      end
      PH_VALUE: begin
        res0_valid      = 1'b1;
        res0.kind       = btsp_pkg::KIND_VALUE;
        res0.value_byte = data_byte;
        value_left_nxt  = value_dec;
        if (value_dec == 16'd0) begin
          phase_nxt = PH_TAG1;
          open_nxt  = pop_open;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_SKIP;
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    if (hdr_go) begin
      res0_valid = 1'b1;
      if (hdr_overrun) begin
        res0.kind       = btsp_pkg::KIND_ERROR;
        res0.error_code = btsp_pkg::ERR_OVERRUN;
        phase_nxt       = PH_SKIP;
      end else if (hdr_first[5] && (open_r >= LW'(MAX_DEPTH))) begin
        res0.kind       = btsp_pkg::KIND_ERROR;
        res0.error_code = btsp_pkg::ERR_TOO_DEEP;
        phase_nxt       = PH_SKIP;
      end else begin
        res0.kind         = btsp_pkg::KIND_HEADER;
        res0.tag          = tag_hold_r;
        res0.tag_class    = hdr_first[7:6];
        res0.constructed  = hdr_first[5];
        res0.value_length = hdr_len;
        phase_nxt         = PH_TAG1;
        if (hdr_len != 16'd0) begin
          if (hdr_first[5]) begin
            push_en  = 1'b1;
            open_nxt = open_r + 1'b1;
          end else begin
            value_left_nxt = hdr_len;
            phase_nxt      = PH_VALUE;
          end
        end else begin
          open_nxt = pop_open;
        end
      end
    end

    trunc = end_of_buffer && (phase_nxt != PH_SKIP) &&
            ((phase_nxt != PH_TAG1) || (open_nxt != '0));
    res1.kind        = btsp_pkg::KIND_ERROR;
    res1.error_code  = btsp_pkg::ERR_TRUNCATED;
    res1.depth       = 3'(open_nxt);
    res1.last_of_run = 1'b1;
    res0.last_of_run = !trunc;

    if (end_of_buffer) begin
      phase_nxt      = PH_TAG1;
      tag_hold_nxt   = 16'd0;
      len_acc_nxt    = 16'd0;
      len_left_nxt   = 2'd0;
      value_left_nxt = 16'd0;
      byte_off_nxt   = '0;
      open_nxt       = '0;
    end
  end

  always_comb begin
    push.count  = {1'b0, res0_valid} + {1'b0, trunc};
    push.first  = res0_valid ? res0 : res1;
    push.second = res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG1;
      tag_hold_r   <= 16'd0;
      len_acc_r    <= 16'd0;
      len_left_r   <= 2'd0;
      value_left_r <= 16'd0;
      byte_off_r   <= '0;
      open_r       <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      tag_hold_r   <= tag_hold_nxt;
      len_acc_r    <= len_acc_nxt;
      len_left_r   <= len_left_nxt;
      value_left_r <= value_left_nxt;
      byte_off_r   <= byte_off_nxt;
      open_r       <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push_en) begin
      level_end_r[open_r[IW-1:0]] <= hdr_end[OFFSET_WIDTH-1:0];
    end
  end

endmodule

### rtl/btsp_result_queue.sv
// ----------------------------------------------------------------------------
// BER-TLV result queue
// Small register queue that takes up to two result words per cycle and
// presents one per cycle on the output channel while the reader takes them.
// ----------------------------------------------------------------------------
module btsp_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  btsp_pkg::push_t     push,
  output logic                has_room,
  output logic                rd_valid,
  input  logic                rd_ready,
  output btsp_pkg::result_t   rd_word
);

  btsp_pkg::result_t                  mem_r [btsp_pkg::QDEPTH];
  logic [btsp_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [btsp_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [btsp_pkg::QCOUNT_W-1:0]      count_r, count_nxt;
  logic [btsp_pkg::QCOUNT_W-1:0]      n_wr;
  logic                               rd_fire;

  assign has_room = (count_r <= btsp_pkg::QCOUNT_W'(btsp_pkg::QDEPTH - 2));
  assign rd_valid = (count_r != '0);
  assign rd_word  = mem_r[rd_ptr_r];
  assign rd_fire  = rd_valid && rd_ready;
  assign n_wr     = wr_en ? btsp_pkg::QCOUNT_W'(push.count) : '0;

  assign wr_ptr_nxt = wr_ptr_r + btsp_pkg::QPTR_W'(n_wr);
  assign rd_ptr_nxt = rd_ptr_r + btsp_pkg::QPTR_W'(rd_fire);
  assign count_nxt  = count_r + n_wr - btsp_pkg::QCOUNT_W'(rd_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (wr_en && push.count == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push.second;
    end
  end

endmodule

### rtl/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// BER-TLV stream parser
// Parses a BER-TLV byte stream into object headers, value bytes and errors.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock while in_ready is high; its results
// are written into a four-entry result queue and read out from there. Most
// bytes cause at most one result word, so a continuous byte stream runs at
// one byte per cycle as long as the output side takes one word per cycle. The
// last byte of a buffer may add a truncation error word; in_ready is low
// while the queue has fewer than two free entries. Up to MAX_DEPTH nested
// constructed objects are tracked, and every level that ends on a byte is
// closed on that same byte by parallel compares against the stored ends.
module ber_tlv_stream_parser #(
  parameter int MAX_DEPTH    = 5,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_tag,
  output logic [1:0]  out_tag_class,
  output logic        out_constructed,
  output logic [15:0] out_value_length,
  output logic [2:0]  out_depth,
  output logic [7:0]  out_value_byte,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  logic              in_fire;
  btsp_pkg::push_t   push;
  btsp_pkg::result_t word;

  assign in_fire = in_valid && in_ready;

  btsp_core #(
    .MAX_DEPTH    (MAX_DEPTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .push          (push)
  );

  btsp_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire),
    .push     (push),
    .has_room (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_word  (word)
  );

  assign out_kind         = word.kind;
  assign out_tag          = word.tag;
  assign out_tag_class    = word.tag_class;
  assign out_constructed  = word.constructed;
  assign out_value_length = word.value_length;
  assign out_depth        = word.depth;
  assign out_value_byte   = word.value_byte;
  assign out_error_code   = word.error_code;
  assign out_last_of_run  = word.last_of_run;

endmodule

### rtl/btsp_checker.sv
// ----------------------------------------------------------------------------
// BER-TLV stream parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module btsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_tag,
  input logic [15:0] out_value_length,
  input logic [7:0]  out_value_byte,
  input logic [2:0]  out_error_code,
  input logic        out_last_of_run
);

  // A stalled word must stay put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tag) &&
      $stable(out_value_byte) && $stable(out_error_code))
    else $error("result word changed while stalled");

  // An error always ends the run of results caused by its byte.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == btsp_pkg::KIND_ERROR |->
      out_last_of_run && out_error_code != btsp_pkg::ERR_NONE && out_tag == 16'd0)
    else $error("malformed error word");

  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == btsp_pkg::KIND_VALUE |->
      out_tag == 16'd0 && out_value_length == 16'd0 &&
      out_error_code == btsp_pkg::ERR_NONE)
    else $error("malformed value word");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == btsp_pkg::KIND_HEADER |->
      out_value_byte == 8'd0 && out_error_code == btsp_pkg::ERR_NONE)
    else $error("malformed header word");

endmodule

bind ber_tlv_stream_parser btsp_checker u_btsp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_tag          (out_tag),
  .out_value_length (out_value_length),
  .out_value_byte   (out_value_byte),
  .out_error_code   (out_error_code),
  .out_last_of_run  (out_last_of_run)
);
